@@ hdl/dsgs_pkg.sv @@
// Package with the shared types and constants of the date sorted group sum block.
package dsgs_pkg;

    // Field widths of the record and group transfers.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMT_W    = 24;
    localparam int TOTAL_W  = 32;
    localparam int KEY_W    = YEAR_W + MONTH_W + DAY_W;

    // Default capacity of the record store.
    localparam int DEF_RECORD_DEPTH = 32;

    // One input record.
    typedef struct packed {
        logic [YEAR_W-1:0]  rec_year;
        logic [MONTH_W-1:0] rec_month;
        logic [DAY_W-1:0]   rec_day;
        logic [AMT_W-1:0]   rec_amount;
        logic               final_record;
    } t_rec;

    // One group result.
    typedef struct packed {
        logic [YEAR_W-1:0]  grp_year;
        logic [MONTH_W-1:0] grp_month;
        logic [DAY_W-1:0]   grp_day;
        logic [TOTAL_W-1:0] grp_total;
        logic               overflow_seen;
        logic               final_group;
    } t_grp;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ins;        // insert the incoming record in date order
        logic drop;       // store is full, note a dropped record
        logic shift;      // pop the head record of the sorted row
        logic acc_load;   // start a new group with the head record
        logic acc_add;    // add the head amount to the current group
        logic emit;       // load the output register with the current group
        logic emit_last;  // the emitted group closes the set
        logic clear;      // end of set: empty the group and overflow flag
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // every record slot is taken
        logic any_left;   // sorted records remain to be summed
        logic acc_valid;  // a group is being summed
        logic head_match; // head record has the date of the current group
        logic out_free;   // output register can take a group this cycle
    } t_sts;

endpackage

@@ hdl/dsgs_ctrl.sv @@
// Controller state machine of the date sorted group sum block.
module dsgs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rec_valid,
    input  logic           i_final,
    input  dsgs_pkg::t_sts i_sts,
    output dsgs_pkg::t_cmd o_cmd,
    output logic           o_rec_stall
);
    import dsgs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a closing record starts the drain, the last group ends it.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_rec_valid && i_final) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.any_left && i_sts.out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd       = '0;
        o_rec_stall = 1'b1;
        unique case (r_state)
            ST_LOAD: begin
                o_rec_stall = 1'b0;
                o_cmd.ins   = i_rec_valid && !i_sts.full;
                o_cmd.drop  = i_rec_valid && i_sts.full;
            end
            ST_DRAIN: begin
                if (i_sts.any_left) begin
                    // Same date extends the group; a new date closes the old one.
                    if (i_sts.acc_valid && i_sts.head_match) begin
                        o_cmd.acc_add = 1'b1;
                        o_cmd.shift   = 1'b1;
                    end else if (i_sts.acc_valid) begin
                        if (i_sts.out_free) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.acc_load = 1'b1;
                            o_cmd.shift    = 1'b1;
                        end
                    end else begin
                        o_cmd.acc_load = 1'b1;
                        o_cmd.shift    = 1'b1;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.clear     = 1'b1;
                end
            end
            default: o_rec_stall = 1'b1;
        endcase
    end

endmodule

@@ hdl/dsgs_datapath.sv @@
// Datapath: sorted insertion row, group accumulator and output register.
module dsgs_datapath #(
    parameter int RECORD_DEPTH = dsgs_pkg::DEF_RECORD_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dsgs_pkg::t_rec i_rec,
    input  dsgs_pkg::t_cmd i_cmd,
    output dsgs_pkg::t_sts o_sts,
    input  logic           i_grp_stall,
    output logic           o_grp_valid,
    output dsgs_pkg::t_grp o_grp
);
    import dsgs_pkg::*;

    localparam int FILL_W = $clog2(RECORD_DEPTH + 1);

    logic [KEY_W-1:0]   r_key [RECORD_DEPTH];
    logic [AMT_W-1:0]   r_amt [RECORD_DEPTH];
    logic [KEY_W-1:0]   n_key [RECORD_DEPTH];
    logic [AMT_W-1:0]   n_amt [RECORD_DEPTH];
    logic [RECORD_DEPTH-1:0] at_or_after;
    logic [FILL_W-1:0]  r_fill;
    logic               r_dropped;
    logic               r_acc_valid;
    logic [KEY_W-1:0]   r_acc_key;
    logic [TOTAL_W-1:0] r_acc_total;
    logic [TOTAL_W:0]   acc_sum;
    logic               r_grp_valid;
    t_grp               r_grp;
    logic [KEY_W-1:0]   new_key;

    assign new_key = {i_rec.rec_year, i_rec.rec_month, i_rec.rec_day};

    // Each slot sees whether it lies at or past the insertion point.
    for (genvar gi = 0; gi < RECORD_DEPTH; gi++) begin : g_slot
        localparam logic [FILL_W-1:0] SLOT_IDX = FILL_W'(gi);
        localparam int NXT = (gi + 1) % RECORD_DEPTH;
        localparam int PRV = (gi + RECORD_DEPTH - 1) % RECORD_DEPTH;

        logic take_next;
        logic take_prev;
        logic take_new;

        assign at_or_after[gi] = (SLOT_IDX >= r_fill) || (r_key[gi] > new_key);

        // Next slot value for an insert or for a pop of the head.
        assign take_next = i_cmd.shift && (gi < RECORD_DEPTH - 1);
        assign take_prev = !i_cmd.shift && i_cmd.ins && (gi > 0) && at_or_after[PRV];
        assign take_new  = !i_cmd.shift && i_cmd.ins && at_or_after[gi];

        assign n_key[gi] = take_next ? r_key[NXT] :
                           take_prev ? r_key[PRV] :
                           take_new  ? new_key    : r_key[gi];
        assign n_amt[gi] = take_next ? r_amt[NXT] :
                           take_prev ? r_amt[PRV] :
                           take_new  ? i_rec.rec_amount : r_amt[gi];
    end

    // Record row registers.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RECORD_DEPTH; k++) begin
            r_key[k] <= n_key[k];
            r_amt[k] <= n_amt[k];
        end
    end

    // Fill count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_cmd.shift) begin
                r_fill <= r_fill - FILL_W'(1);
            end
            if (i_cmd.drop) begin
                r_dropped <= 1'b1;
            end else if (i_cmd.clear) begin
                r_dropped <= 1'b0;
            end
        end
    end

    // Sum of the group total and the head amount, one bit wider to detect overflow.
    assign acc_sum = {1'b0, r_acc_total} + (TOTAL_W + 1)'(r_amt[0]);

    // Group accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
        end else if (i_cmd.clear) begin
            r_acc_valid <= 1'b0;
        end else if (i_cmd.acc_load) begin
            r_acc_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_load) begin
            r_acc_key   <= r_key[0];
            r_acc_total <= TOTAL_W'(r_amt[0]);
        end else if (i_cmd.acc_add) begin
            r_acc_total <= acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];
        end
    end

    // Output register: holds a group until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_grp_valid <= 1'b1;
        end else if (!i_grp_stall) begin
            r_grp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_grp.grp_year      <= r_acc_key[KEY_W-1 -: YEAR_W];
            r_grp.grp_month     <= r_acc_key[DAY_W +: MONTH_W];
            r_grp.grp_day       <= r_acc_key[DAY_W-1:0];
            r_grp.grp_total     <= r_acc_total;
            r_grp.overflow_seen <= r_dropped;
            r_grp.final_group   <= i_cmd.emit_last;
        end
    end

    assign o_grp_valid = r_grp_valid;
    assign o_grp       = r_grp;

    // Status to the controller.
    assign o_sts.full       = (r_fill == FILL_W'(RECORD_DEPTH));
    assign o_sts.any_left   = (r_fill != '0);
    assign o_sts.acc_valid  = r_acc_valid;
    assign o_sts.head_match = (r_key[0] == r_acc_key);
    assign o_sts.out_free   = !r_grp_valid || !i_grp_stall;

endmodule

@@ hdl/date_sorted_group_sum_top.sv @@
// Top level of the date sorted group sum block.
//
//  Channel  Direction  Handshake                  Payload
//  record   in         i_rec_valid / o_rec_stall  i_rec (t_rec)
//  group    out        o_grp_valid / i_grp_stall  o_grp (t_grp)
//
// Each record is inserted in date order into a row of registers, so the set is
// already sorted when the closing record arrives. The drain then pops one
// record per cycle from the head of the row into the group accumulator, but
// waits while a finished group cannot enter the stalled group output. The
// record side is stalled during the drain.
// Reset is synchronous and active low; it empties the row and the output.
module date_sorted_group_sum_top #(
    parameter int RECORD_DEPTH = dsgs_pkg::DEF_RECORD_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rec_valid,
    output logic           o_rec_stall,
    input  dsgs_pkg::t_rec i_rec,
    output logic           o_grp_valid,
    input  logic           i_grp_stall,
    output dsgs_pkg::t_grp o_grp
);
    import dsgs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing of load and drain.
    dsgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (i_rec_valid),
        .i_final     (i_rec.final_record),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rec_stall (o_rec_stall)
    );

    // Record row, accumulator and output register.
    dsgs_datapath #(
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (i_rec),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_grp_stall (i_grp_stall),
        .o_grp_valid (o_grp_valid),
        .o_grp       (o_grp)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for the date sorted group sum block: record sets in, per-date totals checked in order.
module testbench;
    import dsgs_pkg::*;

    localparam int DEPTH         = DEF_RECORD_DEPTH;
    localparam int RANDOM_ITEMS  = 220;
    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 20;
    localparam int MAX_REPORTS   = 50;
    localparam logic [TOTAL_W:0] TOTAL_CAP = {1'b0, {TOTAL_W{1'b1}}};

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic rec_valid = 1'b0;
    t_rec rec_data  = '0;
    logic rec_stall;
    logic grp_valid;
    logic grp_stall = 1'b0;
    t_grp grp_data;

    // Records waiting to be sent, and group totals waiting to be seen.
    t_rec rec_pending[$];
    t_grp grp_expect[$];

    // Records of the open set, kept in date order as they arrive.
    logic [KEY_W-1:0] set_key[DEPTH];
    logic [AMT_W-1:0] set_amt[DEPTH];
    int   set_count   = 0;
    logic set_dropped = 1'b0;

    int err_count   = 0;
    int hold_req    = 0;
    int idle_cycles = 0;
    int queued      = 0;

    date_sorted_group_sum_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_rec_valid (rec_valid),
        .o_rec_stall (rec_stall),
        .i_rec       (rec_data),
        .o_grp_valid (grp_valid),
        .i_grp_stall (grp_stall),
        .o_grp       (grp_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Count a mismatch and print one line about it.
    task automatic report(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Insert one record into the open set; on the closing record, emit its date totals.
    task automatic sum_by_date(input t_rec r);
        logic [KEY_W-1:0] key;
        logic [TOTAL_W:0] total;
        t_grp g;
        int pos;
        int k;
        key = {r.rec_year, r.rec_month, r.rec_day};
        if (set_count < DEPTH) begin
            // Records of equal date keep arrival order; only later dates move up.
            pos = set_count;
            while (pos > 0 && set_key[pos-1] > key) begin
                set_key[pos] = set_key[pos-1];
                set_amt[pos] = set_amt[pos-1];
                pos--;
            end
            set_key[pos] = key;
            set_amt[pos] = r.rec_amount;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (r.final_record) begin
            total = '0;
            for (k = 0; k < set_count; k++) begin
                if (k == 0 || set_key[k] != set_key[k-1]) begin
                    total = {{(TOTAL_W + 1 - AMT_W){1'b0}}, set_amt[k]};
                end else begin
                    total = total + {{(TOTAL_W + 1 - AMT_W){1'b0}}, set_amt[k]};
                    if (total > TOTAL_CAP) total = TOTAL_CAP;
                end
                // A group closes where the next date differs or the set ends.
                if (k == set_count - 1 || set_key[k+1] != set_key[k]) begin
                    g.grp_year      = set_key[k][KEY_W-1:MONTH_W+DAY_W];
                    g.grp_month     = set_key[k][MONTH_W+DAY_W-1:DAY_W];
                    g.grp_day       = set_key[k][DAY_W-1:0];
                    g.grp_total     = total[TOTAL_W-1:0];
                    g.overflow_seen = set_dropped;
                    g.final_group   = (k == set_count - 1);
                    grp_expect.push_back(g);
                end
            end
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Compare one group transfer with the oldest expected total.
    task automatic check_group(input t_grp got);
        t_grp want;
        if (grp_expect.size() == 0) begin
            report($sformatf("group %0d-%0d-%0d total %0d with no expectation waiting",
                             got.grp_year, got.grp_month, got.grp_day, got.grp_total));
            return;
        end
        want = grp_expect.pop_front();
        cmp_field("grp_year", 32'(got.grp_year), 32'(want.grp_year));
        cmp_field("grp_month", 32'(got.grp_month), 32'(want.grp_month));
        cmp_field("grp_day", 32'(got.grp_day), 32'(want.grp_day));
        cmp_field("grp_total", got.grp_total, want.grp_total);
        cmp_field("overflow_seen", 32'(got.overflow_seen), 32'(want.overflow_seen));
        cmp_field("final_group", 32'(got.final_group), 32'(want.final_group));
    endtask

    // Record driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            rec_valid <= 1'b0;
        end else begin
            if (rec_valid && !rec_stall) sum_by_date(rec_data);
            // A stalled transfer holds its payload; otherwise take the next step.
            if (!(rec_valid && rec_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rec_valid <= 1'b0;
                end else if (rec_pending.size() > 0) begin
                    rec_data  <= rec_pending.pop_front();
                    rec_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    rec_valid <= 1'b0;
                end
            end
        end
    end

    // Group monitor with its own stall pattern and a long hold on request.
    int mode_left = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            grp_stall <= 1'b0;
        end else begin
            if (grp_valid && !grp_stall) check_group(grp_data);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                grp_stall <= 1'b1;
            end else begin
                grp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Watchdog: cycles with work outstanding but no transfer on either channel.
    always @(posedge clk) begin
        if ((rec_valid && !rec_stall) || (grp_valid && !grp_stall) ||
            (!rec_valid && grp_expect.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_rec(input logic [KEY_W-1:0] key, input logic [AMT_W-1:0] amt,
                            input logic last);
        t_rec r;
        r.rec_year     = key[KEY_W-1:MONTH_W+DAY_W];
        r.rec_month    = key[MONTH_W+DAY_W-1:DAY_W];
        r.rec_day      = key[DAY_W-1:0];
        r.rec_amount   = amt;
        r.final_record = last;
        rec_pending.push_back(r);
    endtask

    // Mostly calendar dates, often in a few recent years; sometimes raw bit patterns.
    function automatic logic [KEY_W-1:0] rand_date();
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        if ($urandom_range(0, 6) == 0) begin
            y = YEAR_W'($urandom_range(0, 2**YEAR_W - 1));
            m = MONTH_W'($urandom_range(0, 2**MONTH_W - 1));
            d = DAY_W'($urandom_range(0, 2**DAY_W - 1));
        end else begin
            y = YEAR_W'($urandom_range(0, 1) ? $urandom_range(2020, 2023)
                                             : $urandom_range(0, 9999));
            m = MONTH_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, 31));
        end
        return {y, m, d};
    endfunction

    // Set sizes: mostly short, some up to capacity, a few beyond it.
    function automatic int rand_len();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) return $urandom_range(1, 8);
        if (p < 9) return $urandom_range(9, DEPTH);
        return $urandom_range(DEPTH + 1, DEPTH + 4);
    endfunction

    // Queue one set whose dates come mostly from a small pool, so groups form.
    task automatic queue_set(input int len);
        logic [KEY_W-1:0] pool[8];
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amt;
        int npool;
        int k;
        npool = $urandom_range(1, 8);
        for (k = 0; k < npool; k++) pool[k] = rand_date();
        for (k = 0; k < len; k++) begin
            key = ($urandom_range(0, 4) == 0) ? rand_date() : pool[$urandom_range(0, npool - 1)];
            case ($urandom_range(0, 9))
                0: amt = '0;
                1: amt = '1;
                default: amt = AMT_W'($urandom_range(0, 2**AMT_W - 1));
            endcase
            push_rec(key, amt, k == len - 1);
        end
        queued += len;
    endtask

    // Sender pause: wait until every record is sent and every total has arrived.
    task automatic wait_drained();
        do @(negedge clk);
        while (rec_pending.size() != 0 || rec_valid || grp_expect.size() != 0);
    endtask

    // Stimulus: directed sets, then random sets in phases.
    initial begin
        int phase_end;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-record sets at the earliest calendar date of year zero and at the all-ones field values.
        push_rec({14'd0, 4'd1, 5'd1}, 24'd0, 1'b1);
        push_rec({14'h3FFF, 4'hF, 5'h1F}, 24'hFFFFFF, 1'b1);

        // Dates out of order with repeats across year, month and day.
        push_rec({14'd2024, 4'd3, 5'd15}, 24'd100, 1'b0);
        push_rec({14'd2023, 4'd12, 5'd31}, 24'd5, 1'b0);
        push_rec({14'd2024, 4'd3, 5'd15}, 24'hFFFFFF, 1'b0);
        push_rec({14'd2024, 4'd2, 5'd15}, 24'd7, 1'b0);
        push_rec({14'd2023, 4'd12, 5'd31}, 24'd1, 1'b0);
        push_rec({14'd2024, 4'd3, 5'd14}, 24'd9, 1'b1);

        // One date only, largest amounts: a single group with a wide total.
        repeat (3) push_rec({14'd1999, 4'd6, 5'd6}, 24'hFFFFFF, 1'b0);
        push_rec({14'd1999, 4'd6, 5'd6}, 24'hFFFFFF, 1'b1);

        // Raw bit patterns: year outranks month, month outranks day.
        push_rec({14'h3FFF, 4'd0, 5'd0}, 24'd4, 1'b0);
        push_rec({14'd0, 4'hF, 5'd0}, 24'd3, 1'b0);
        push_rec({14'd0, 4'd0, 5'h1F}, 24'd2, 1'b0);
        push_rec({14'd1, 4'd0, 5'd0}, 24'd5, 1'b0);
        push_rec({14'd0, 4'd0, 5'd0}, 24'd1, 1'b1);
        wait_drained();

        // Long output hold while a short set, a full set and two overfull ones are offered;
        // both overfull sets also lose their closing record.
        hold_req++;
        queue_set(5);
        queue_set(DEPTH);
        queue_set(DEPTH + 1);
        queue_set(DEPTH + 3);
        wait_drained();

        while (queued < RANDOM_ITEMS) begin
            phase_end = queued + 60;
            while (queued < phase_end && queued < RANDOM_ITEMS) queue_set(rand_len());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/dsgs_pkg.sv
hdl/dsgs_ctrl.sv
hdl/dsgs_datapath.sv
hdl/date_sorted_group_sum_top.sv
tb/testbench.sv
